// ===== rtl/two_pole_lowpass_biquad_defines.svh =====
// assertion macros shared by the biquad modules
`ifndef TWO_POLE_LOWPASS_BIQUAD_DEFINES_SVH
`define TWO_POLE_LOWPASS_BIQUAD_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define BQD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BQD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bqd_pkg.sv =====
// shared types and constants of the two-pole low-pass biquad
package bqd_pkg;

    // parameter defaults
    localparam int SAMPLE_WIDTH_DEF   = 14;
    localparam int COEF_FRAC_BITS_DEF = 22;

    // fixed widths
    localparam int DELAY_W         = 48;
    localparam int SCALE_W         = 32;
    localparam int SCALE_FRAC_BITS = 16;
    localparam int CFG_DATA_W      = 32;
    localparam int CFG_IDX_W       = 3;
    localparam int MUL_A_W         = 64;
    localparam int MUL_B_W         = 33;
    localparam int MUL_OP_W        = 32;
    localparam int SHAMT_W         = 7;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_B0     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_A1     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_A2     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 3'd4;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PRIME,
        S_T1,
        S_T2,
        S_SUM,
        S_Y,
        S_OUT
    } t_state;

    // product scaling selected per multiply
    typedef enum logic [1:0] {
        SH_SCALE,
        SH_COEF,
        SH_OUT
    } t_shift;

    // request from the sequencer to the multiply unit
    typedef struct packed {
        logic   start;
        t_shift shift;
    } t_mul_req;

endpackage

// ===== rtl/bqd_mul.sv =====
// shared multiply unit: 64x33 signed product over two 32x32 passes, round, shift, saturate
module bqd_mul #(
    parameter int COEF_FRAC_BITS = bqd_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  bqd_pkg::t_mul_req                     i_req,
    input  logic signed [bqd_pkg::MUL_A_W-1:0]    i_a,
    input  logic signed [bqd_pkg::MUL_B_W-1:0]    i_b,
    output logic                                  o_done,
    output logic signed [bqd_pkg::DELAY_W-1:0]    o_result
);
    import bqd_pkg::*;

    localparam int ACC_W = MUL_A_W + MUL_OP_W;
    localparam int FIN_W = ACC_W + 2;
    localparam logic [1:0] PH_LAST = 2'd3;

    logic                       r_busy;
    logic                       r_done;
    logic [1:0]                 r_phase;
    logic [MUL_A_W-1:0]         r_mag_a;
    logic [MUL_OP_W-1:0]        r_mag_b;
    logic                       r_neg;
    t_shift                     r_shift;
    logic [2*MUL_OP_W-1:0]      r_prod;
    logic [ACC_W-1:0]           r_acc;
    logic signed [DELAY_W-1:0]  r_result;

    logic [MUL_A_W-1:0]         w_abs_a;
    logic [MUL_B_W-1:0]         w_abs_b;
    logic [MUL_OP_W-1:0]        w_op_a;
    logic [2*MUL_OP_W-1:0]      w_prod;
    logic [SHAMT_W-1:0]         w_shamt;
    logic signed [FIN_W-1:0]    w_signed;
    logic signed [FIN_W-1:0]    w_rounded;
    logic signed [FIN_W-1:0]    w_shifted;
    logic signed [DELAY_W-1:0]  w_sat;

    // operand magnitudes
    assign w_abs_a = i_a[MUL_A_W-1] ? MUL_A_W'(-i_a) : MUL_A_W'(i_a);
    assign w_abs_b = i_b[MUL_B_W-1] ? MUL_B_W'(-i_b) : MUL_B_W'(i_b);

    // the one multiplier, low half of a first, high half second
    assign w_op_a = (r_phase == 2'd0) ? r_mag_a[MUL_OP_W-1:0]
                                      : r_mag_a[MUL_A_W-1:MUL_OP_W];
    assign w_prod = (2*MUL_OP_W)'(w_op_a) * (2*MUL_OP_W)'(r_mag_b);

    // shift amount for the selected scaling
    always_comb begin
        unique case (r_shift)
            SH_SCALE: w_shamt = SHAMT_W'(SCALE_FRAC_BITS);
            SH_COEF:  w_shamt = SHAMT_W'(COEF_FRAC_BITS);
            SH_OUT:   w_shamt = SHAMT_W'(2 * COEF_FRAC_BITS);
            default:  w_shamt = SHAMT_W'(COEF_FRAC_BITS);
        endcase
    end

    // sign, round half up, arithmetic shift, saturate to delay width
    always_comb begin
        w_signed  = r_neg ? -$signed({2'b00, r_acc}) : $signed({2'b00, r_acc});
        w_rounded = w_signed + $signed(FIN_W'(1) << (w_shamt - SHAMT_W'(1)));
        w_shifted = w_rounded >>> w_shamt;
        if (w_shifted[FIN_W-1:DELAY_W-1] == {(FIN_W-DELAY_W+1){w_shifted[DELAY_W-1]}}) begin
            w_sat = w_shifted[DELAY_W-1:0];
        end else if (w_shifted[FIN_W-1]) begin
            w_sat = {1'b1, {(DELAY_W-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(DELAY_W-1){1'b1}}};
        end
    end

    // control: busy flag, phase counter, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_phase <= 2'd0;
            end else if (r_busy) begin
                r_phase <= r_phase + 2'd1;
                if (r_phase == PH_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mag_a <= w_abs_a;
            r_mag_b <= w_abs_b[MUL_OP_W-1:0];
            r_neg   <= i_a[MUL_A_W-1] ^ i_b[MUL_B_W-1];
            r_shift <= i_req.shift;
        end else if (r_busy) begin
            unique case (r_phase)
                2'd0: r_prod <= w_prod;
                2'd1: begin
                    r_acc  <= ACC_W'(r_prod);
                    r_prod <= w_prod;
                end
                2'd2: r_acc <= r_acc + {r_prod, {MUL_OP_W{1'b0}}};
                2'd3: r_result <= w_sat;
                default: r_result <= w_sat;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    `include "two_pole_lowpass_biquad_defines.svh"

    `BQD_ASSERT_IMP(a_no_start_busy, i_req.start, !r_busy, "multiply started while busy")
    `BQD_ASSERT_IMP(a_done_after_last, r_done, $past(r_busy) && ($past(r_phase) == PH_LAST), "done without final phase")
    `BQD_ASSERT_IMP(a_done_idle, r_done, !r_busy, "unit busy while reporting done")

endmodule

// ===== rtl/two_pole_lowpass_biquad.sv =====
// top level of the two-pole low-pass biquad: registers, sequencer, output stage
//
//  channel   signals                                     direction
//  input     i_in_valid / o_in_ready / i_sample_in       in
//  output    o_out_valid / i_out_ready / o_sample_out    out
//  config    i_cfg_we / i_cfg_index / i_cfg_data         in, write only
//
//  Enabled samples pass products a1*d1, a2*d2, a sum and the output product, after a
//  priming product on the first sample after reset or a register write; bypassed
//  samples go straight to the output state. One 32x32 multiplier does every product.
//  Reset is synchronous, active low; no item is taken until the previous one sits in
//  the output register. A stalled output holds the sequencer in its output state.
module two_pole_lowpass_biquad #(
    parameter int SAMPLE_WIDTH   = bqd_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = bqd_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]       i_sample_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]       o_sample_out,
    input  logic                                 i_cfg_we,
    input  logic [bqd_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [bqd_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import bqd_pkg::*;

    localparam int COEF_W = COEF_FRAC_BITS + 2;
    localparam int XS_W   = SAMPLE_WIDTH + COEF_FRAC_BITS;
    localparam logic signed [MUL_A_W-1:0] D_MAX = {{(MUL_A_W-DELAY_W+1){1'b0}},
                                                   {(DELAY_W-1){1'b1}}};
    localparam logic signed [MUL_A_W-1:0] D_MIN = ~D_MAX;
    localparam logic signed [DELAY_W-1:0] Y_MAX = {{(DELAY_W-SAMPLE_WIDTH+1){1'b0}},
                                                   {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [DELAY_W-1:0] Y_MIN = ~Y_MAX;

    // configuration registers
    logic                       r_enable;
    logic signed [COEF_W-1:0]   r_b0;
    logic signed [COEF_W-1:0]   r_a1;
    logic signed [COEF_W-1:0]   r_a2;
    logic [SCALE_W-1:0]         r_scale;

    // filter state and work registers
    t_state                     r_state;
    t_state                     n_state;
    logic                       r_primed;
    logic                       r_issued;
    logic signed [SAMPLE_WIDTH-1:0] r_x;
    logic signed [DELAY_W-1:0]  r_d1;
    logic signed [DELAY_W-1:0]  r_d2;
    logic signed [DELAY_W-1:0]  r_t1;
    logic signed [DELAY_W-1:0]  r_t2;
    logic signed [DELAY_W-1:0]  r_d0;
    logic signed [SAMPLE_WIDTH-1:0] r_y;
    logic                       r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_sample_out;

    // multiply unit hookup
    t_mul_req                   w_req;
    logic signed [MUL_A_W-1:0]  w_mul_a;
    logic signed [MUL_B_W-1:0]  w_mul_b;
    logic                       w_mul_done;
    logic signed [DELAY_W-1:0]  w_mul_res;

    logic signed [MUL_A_W-1:0]  w_xs;
    logic signed [MUL_A_W-1:0]  w_acc;
    logic signed [MUL_A_W-1:0]  w_sum;
    logic signed [DELAY_W-1:0]  w_d0;
    logic signed [SAMPLE_WIDTH-1:0] w_y;
    logic                       w_out_load;

    // sample scaled to the delay format
    assign w_xs = {{(MUL_A_W-XS_W){r_x[SAMPLE_WIDTH-1]}}, r_x, {COEF_FRAC_BITS{1'b0}}};

    // feedforward sum d0 + 2*d1 + d2
    assign w_acc = MUL_A_W'(r_d0) + (MUL_A_W'(r_d1) <<< 1) + MUL_A_W'(r_d2);

    // new delay element, saturated
    assign w_sum = w_xs - MUL_A_W'(r_t1) - MUL_A_W'(r_t2);
    always_comb begin
        if (w_sum > D_MAX) begin
            w_d0 = D_MAX[DELAY_W-1:0];
        end else if (w_sum < D_MIN) begin
            w_d0 = D_MIN[DELAY_W-1:0];
        end else begin
            w_d0 = w_sum[DELAY_W-1:0];
        end
    end

    // output saturated to the sample range
    always_comb begin
        if (w_mul_res > Y_MAX) begin
            w_y = Y_MAX[SAMPLE_WIDTH-1:0];
        end else if (w_mul_res < Y_MIN) begin
            w_y = Y_MIN[SAMPLE_WIDTH-1:0];
        end else begin
            w_y = w_mul_res[SAMPLE_WIDTH-1:0];
        end
    end

    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_b0     <= '0;
            r_a1     <= '0;
            r_a2     <= '0;
            r_scale  <= SCALE_W'(1) << SCALE_FRAC_BITS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ENABLE: r_enable <= i_cfg_data[0];
                CFG_B0:     r_b0     <= i_cfg_data[COEF_W-1:0];
                CFG_A1:     r_a1     <= i_cfg_data[COEF_W-1:0];
                CFG_A2:     r_a2     <= i_cfg_data[COEF_W-1:0];
                CFG_SCALE:  r_scale  <= i_cfg_data[SCALE_W-1:0];
                default:    ;
            endcase
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and multiply requests
    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        w_req.start = 1'b0;
        w_req.shift = SH_COEF;
        w_mul_a     = '0;
        w_mul_b     = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (!r_enable) begin
                        n_state = S_OUT;
                    end else if (r_primed) begin
                        n_state = S_T1;
                    end else begin
                        n_state = S_PRIME;
                    end
                end
            end
            S_PRIME: begin
                w_req.start = !r_issued;
                w_req.shift = SH_SCALE;
                w_mul_a     = w_xs;
                w_mul_b     = $signed({1'b0, r_scale});
                if (w_mul_done) n_state = S_T1;
            end
            S_T1: begin
                w_req.start = !r_issued;
                w_mul_a     = MUL_A_W'(r_d1);
                w_mul_b     = MUL_B_W'(r_a1);
                if (w_mul_done) n_state = S_T2;
            end
            S_T2: begin
                w_req.start = !r_issued;
                w_mul_a     = MUL_A_W'(r_d2);
                w_mul_b     = MUL_B_W'(r_a2);
                if (w_mul_done) n_state = S_SUM;
            end
            S_SUM: begin
                n_state = S_Y;
            end
            S_Y: begin
                w_req.start = !r_issued;
                w_req.shift = SH_OUT;
                w_mul_a     = w_acc;
                w_mul_b     = MUL_B_W'(r_b0);
                if (w_mul_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control flags: multiply in flight, delays primed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issued <= 1'b0;
            r_primed <= 1'b0;
        end else begin
            if (w_req.start) begin
                r_issued <= 1'b1;
            end else if (w_mul_done) begin
                r_issued <= 1'b0;
            end
            if (i_cfg_we && (i_cfg_index <= CFG_SCALE)) begin
                r_primed <= 1'b0;
            end else if ((r_state == S_PRIME) && w_mul_done) begin
                r_primed <= 1'b1;
            end
        end
    end

    // delay line and work registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1 <= '0;
            r_d2 <= '0;
        end else begin
            unique case (r_state)
                S_PRIME: begin
                    if (w_mul_done) begin
                        r_d1 <= w_mul_res;
                        r_d2 <= w_mul_res;
                    end
                end
                S_Y: begin
                    if (w_mul_done) begin
                        r_d2 <= r_d1;
                        r_d1 <= r_d0;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers of the current transaction
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_x <= i_sample_in;
                    r_y <= i_sample_in;
                end
            end
            S_T1:    if (w_mul_done) r_t1 <= w_mul_res;
            S_T2:    if (w_mul_done) r_t2 <= w_mul_res;
            S_SUM:   r_d0 <= w_d0;
            S_Y:     if (w_mul_done) r_y <= w_y;
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_sample_out <= r_y;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;

    // shared multiply unit
    bqd_mul #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_req),
        .i_a      (w_mul_a),
        .i_b      (w_mul_b),
        .o_done   (w_mul_done),
        .o_result (w_mul_res)
    );

    `include "two_pole_lowpass_biquad_defines.svh"

    `BQD_ASSERT_IMP(a_out_from_seq, $rose(o_out_valid), $past(r_state) == S_OUT, "output loaded outside output state")
    `BQD_ASSERT_NXT(a_y_to_out, (r_state == S_Y) && w_mul_done, r_state == S_OUT, "output product not followed by output state")
    `BQD_ASSERT_IMP(a_done_issued, w_mul_done, r_issued, "multiply result without a request")

endmodule
